>>> design/psbf_pkg.sv
package psbf_pkg;

   // default limits, handed down as top-level parameters
   localparam int MAX_PREAMBLE_BITS_DEF = 255;
   localparam int MAX_SYNC_BITS_DEF     = 64;

   // field widths
   localparam int SYNC_WORD_W = 64;
   localparam int SYNC_LEN_W  = 7;
   localparam int PRE_LEN_W   = 8;
   localparam int BYTE_W      = 8;
   localparam int CHUNK_W     = 8;
   localparam int CHUNK_CNT_W = 4;
   localparam int CSR_INDEX_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_LEN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_LEN       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_BIT_FIRST = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS        = 3'd4;

   // register reset values
   localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RST = 64'h0000_0000_3699_4625;
   localparam logic [SYNC_LEN_W-1:0]  SYNC_LEN_RST  = 7'd32;
   localparam logic [PRE_LEN_W-1:0]   PRE_LEN_RST   = 8'd64;

   // preamble bits in a chunk: 0 at even positions, 1 at odd ones
   localparam logic [CHUNK_W-1:0] PREAMBLE_PATTERN = 8'hAA;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_present;
      logic              frame_last;
   } req_payload_type;

   typedef struct packed {
      logic [CHUNK_W-1:0]     chunk_bits;
      logic [CHUNK_CNT_W-1:0] chunk_count;
      logic                   frame_done;
      logic                   run_last;
   } rsp_payload_type;

   // job field widths
   function automatic int pre_cnt_width(input int max_pre);
      return (max_pre > 0) ? $clog2(max_pre + 1) : 1;
   endfunction

   function automatic int tail_width(input int max_sync);
      return max_sync + BYTE_W;
   endfunction

   function automatic int tail_cnt_width(input int max_sync);
      return $clog2(max_sync + BYTE_W + 1);
   endfunction

   function automatic int job_width(input int max_pre, input int max_sync);
      return pre_cnt_width(max_pre) + tail_width(max_sync) + tail_cnt_width(max_sync) + 1;
   endfunction

   function automatic logic [SYNC_WORD_W-1:0] rev64(input logic [SYNC_WORD_W-1:0] v);
      logic [SYNC_WORD_W-1:0] r;
      for (int i = 0; i < SYNC_WORD_W; i++) begin
         r[i] = v[SYNC_WORD_W-1-i];
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

>>> design/preamble_sync_bit_framer_unit.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_payload (data_byte, byte_present, frame_last)
// rsp       out        rsp_valid / rsp_stall   rsp_payload (chunk_bits, chunk_count, frame_done,
//                                                           run_last)
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// One chunk per cycle unless stalled: an item gives N chunks, N = max(1, ceil(bits / 8)), where
// bits is preamble + sync + byte (8 or 0) on a frame's first item outside bypass, else N = 1.
// Unstalled, one item per cycle is sustained while items yield one chunk each; rsp_valid rises
// after the item passes the queue and output register. Two jobs queue between front and back.
// Synchronous reset restores the register defaults and closes any open frame.
// req_stall rises only when both queue slots hold jobs; rsp_stall holds the output register.
module preamble_sync_bit_framer_unit #(
   parameter int MAX_PREAMBLE_BITS = psbf_pkg::MAX_PREAMBLE_BITS_DEF,
   parameter int MAX_SYNC_BITS     = psbf_pkg::MAX_SYNC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psbf_pkg::SYNC_WORD_W-1:0] csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  psbf_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output psbf_pkg::rsp_payload_type        rsp_payload
);
   import psbf_pkg::*;

   localparam int JOB_W = job_width(MAX_PREAMBLE_BITS, MAX_SYNC_BITS);

   logic             push;
   logic [JOB_W-1:0] push_job;
   logic             q_full;
   logic             pop;
   logic             head_valid;
   logic [JOB_W-1:0] head_job;

   assign req_stall = q_full;

   // classify items and hold the config registers
   psbf_front #(
      .MAX_PREAMBLE_BITS(MAX_PREAMBLE_BITS),
      .MAX_SYNC_BITS    (MAX_SYNC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .q_full     (q_full),
      .req_payload(req_payload),
      .push       (push),
      .push_job   (push_job)
   );

   // job queue
   psbf_queue #(
      .WIDTH(JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_job)
   );

   // chunk generator and output register
   psbf_back #(
      .MAX_PREAMBLE_BITS(MAX_PREAMBLE_BITS),
      .MAX_SYNC_BITS    (MAX_SYNC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

>>> design/psbf_front.sv
module psbf_front #(
   parameter int MAX_PREAMBLE_BITS = psbf_pkg::MAX_PREAMBLE_BITS_DEF,
   parameter int MAX_SYNC_BITS     = psbf_pkg::MAX_SYNC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [psbf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [psbf_pkg::SYNC_WORD_W-1:0]       csr_data,
   input  logic                                   req_valid,
   input  logic                                   q_full,
   input  psbf_pkg::req_payload_type              req_payload,
   output logic                                   push,
   output logic [psbf_pkg::job_width(MAX_PREAMBLE_BITS, MAX_SYNC_BITS)-1:0] push_job
);
   import psbf_pkg::*;

   localparam int PRE_W  = pre_cnt_width(MAX_PREAMBLE_BITS);
   localparam int TAIL_W = tail_width(MAX_SYNC_BITS);
   localparam int TCNT_W = tail_cnt_width(MAX_SYNC_BITS);

   typedef struct packed {
      logic [PRE_W-1:0]  pre_cnt;
      logic [TAIL_W-1:0] tail;
      logic [TCNT_W-1:0] tail_cnt;
      logic              frame_last;
   } job_type;

   logic [SYNC_WORD_W-1:0] sync_word_ff;
   logic [SYNC_LEN_W-1:0]  sync_len_ff;
   logic [PRE_LEN_W-1:0]   pre_len_ff;
   logic                   low_bit_first_ff;
   logic                   bypass_ff;
   logic                   frame_open_ff;
   logic                   frame_open_in;

   logic                   csr_we;
   logic [SYNC_LEN_W-1:0]  slen;
   logic [PRE_W-1:0]       plen;
   logic                   hdr;
   logic [SYNC_LEN_W-1:0]  s_eff;
   logic [SYNC_WORD_W-1:0] sync_al;
   logic [BYTE_W-1:0]      ordered;
   job_type                job;

   // config writes are always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff     <= SYNC_WORD_RST;
         sync_len_ff      <= SYNC_LEN_RST;
         pre_len_ff       <= PRE_LEN_RST;
         low_bit_first_ff <= 1'b0;
         bypass_ff        <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_WORD:     sync_word_ff     <= csr_data;
            CSR_SYNC_LEN:      sync_len_ff      <= csr_data[SYNC_LEN_W-1:0];
            CSR_PRE_LEN:       pre_len_ff       <= csr_data[PRE_LEN_W-1:0];
            CSR_LOW_BIT_FIRST: low_bit_first_ff <= csr_data[0];
            CSR_BYPASS:        bypass_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   // frame tracking, bypass or not
   assign push          = req_valid && !q_full;
   assign frame_open_in = push ? !req_payload.frame_last : frame_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else begin
         frame_open_ff <= frame_open_in;
      end
   end

   // classify the item into preamble count and a tail bit vector, bit 0 sent first
   always_comb begin
      slen = (32'(sync_len_ff) > 32'(MAX_SYNC_BITS)) ? SYNC_LEN_W'(MAX_SYNC_BITS) : sync_len_ff;
      plen = (32'(pre_len_ff) > 32'(MAX_PREAMBLE_BITS)) ? PRE_W'(MAX_PREAMBLE_BITS)
                                                          : PRE_W'(pre_len_ff);
      hdr   = !bypass_ff && !frame_open_ff;
      s_eff = hdr ? slen : '0;
      // sync word low s_eff bits, msb first, land at tail bits 0..s_eff-1
      sync_al = rev64(sync_word_ff) >> (SYNC_LEN_W'(SYNC_WORD_W) - s_eff);
      if (!req_payload.byte_present) begin
         ordered = '0;
      end else if (bypass_ff || low_bit_first_ff) begin
         ordered = req_payload.data_byte;
      end else begin
         ordered = rev8(req_payload.data_byte);
      end
      job.pre_cnt    = hdr ? plen : '0;
      job.tail       = TAIL_W'(sync_al[MAX_SYNC_BITS-1:0]) | (TAIL_W'(ordered) << s_eff);
      job.tail_cnt   = TCNT_W'(s_eff) + (req_payload.byte_present ? TCNT_W'(BYTE_W) : '0);
      job.frame_last = req_payload.frame_last;
   end

   assign push_job = job;

   // bypass items carry no header and at most one byte
   a_bypass_job: assert property (@(posedge clock) disable iff (reset)
      push && bypass_ff |-> job.pre_cnt == '0 && 32'(job.tail_cnt) <= BYTE_W)
      else $error("bypass job carries header bits");

   // the back end relies on zero bits past the tail count
   a_tail_clean: assert property (@(posedge clock) disable iff (reset)
      push |-> (job.tail >> job.tail_cnt) == '0)
      else $error("tail has stray bits past its count");

   // a frame is open after any accepted item that does not end it
   a_frame_track: assert property (@(posedge clock) disable iff (reset)
      push |=> frame_open_ff == !$past(req_payload.frame_last))
      else $error("frame tracking out of step");

endmodule

>>> design/psbf_queue.sv
module psbf_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import psbf_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("job queue count out of range");

endmodule

>>> design/psbf_back.sv
module psbf_back #(
   parameter int MAX_PREAMBLE_BITS = psbf_pkg::MAX_PREAMBLE_BITS_DEF,
   parameter int MAX_SYNC_BITS     = psbf_pkg::MAX_SYNC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   head_valid,
   input  logic [psbf_pkg::job_width(MAX_PREAMBLE_BITS, MAX_SYNC_BITS)-1:0] head_job,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output psbf_pkg::rsp_payload_type              rsp_payload
);
   import psbf_pkg::*;

   localparam int PRE_W  = pre_cnt_width(MAX_PREAMBLE_BITS);
   localparam int TAIL_W = tail_width(MAX_SYNC_BITS);
   localparam int TCNT_W = tail_cnt_width(MAX_SYNC_BITS);

   typedef struct packed {
      logic [PRE_W-1:0]  pre_cnt;
      logic [TAIL_W-1:0] tail;
      logic [TCNT_W-1:0] tail_cnt;
      logic              frame_last;
   } job_type;

   logic            active_ff, active_in;
   job_type         work_ff, work_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   job_type                cur;
   logic                   out_free;
   logic                   gen;
   logic [CHUNK_CNT_W-1:0] n_p, n_t, room;
   logic [CHUNK_W-1:0]     pre_mask;
   logic [CHUNK_W-1:0]     chunk;
   logic [PRE_W-1:0]       pre_left;
   logic [TCNT_W-1:0]      tail_left;
   logic                   done;

   // a chunk is built when the output register is empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign gen      = out_free && (active_ff || head_valid);
   assign pop      = gen && !active_ff;

   // one chunk: preamble bits first, then tail bits, up to eight in all
   always_comb begin
      cur       = active_ff ? work_ff : job_type'(head_job);
      n_p       = (32'(cur.pre_cnt) >= CHUNK_W) ? CHUNK_CNT_W'(CHUNK_W)
                                                : CHUNK_CNT_W'(cur.pre_cnt);
      room      = CHUNK_CNT_W'(CHUNK_W) - n_p;
      n_t       = (32'(cur.tail_cnt) >= 32'(room)) ? room : CHUNK_CNT_W'(cur.tail_cnt);
      pre_mask  = CHUNK_W'((9'd1 << n_p) - 9'd1);
      chunk     = (PREAMBLE_PATTERN & pre_mask)
                | CHUNK_W'(16'(cur.tail[CHUNK_W-1:0]) << n_p);
      pre_left  = cur.pre_cnt - PRE_W'(n_p);
      tail_left = cur.tail_cnt - TCNT_W'(n_t);
      done      = (pre_left == '0) && (tail_left == '0);

      work_in.pre_cnt    = pre_left;
      work_in.tail       = cur.tail >> n_t;
      work_in.tail_cnt   = tail_left;
      work_in.frame_last = cur.frame_last;

      rsp_in.chunk_bits  = chunk;
      rsp_in.chunk_count = n_p + n_t;
      rsp_in.frame_done  = done && cur.frame_last;
      rsp_in.run_last    = done;

      active_in    = gen ? !done : active_ff;
      rsp_valid_in = gen || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working job and output payload
   always_ff @(posedge clock) begin
      if (gen) begin
         work_ff <= work_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_bits_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_ff.chunk_count) <= CHUNK_W
                       && (rsp_ff.chunk_bits >> rsp_ff.chunk_count) == '0)
      else $error("chunk has bits past its count");

   a_active_work: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (work_ff.pre_cnt != '0 || work_ff.tail_cnt != '0))
      else $error("running job has no bits left");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done |-> rsp_ff.run_last)
      else $error("frame end flagged before the last chunk of its item");

endmodule

>>> bench/psbf_chunk_checker.sv
`timescale 1ns / 1ps

// Watches the register, item and chunk channels of the framer.
// It predicts the chunks for every accepted item and compares them in order.
module psbf_chunk_checker #(
   parameter int MAX_PREAMBLE_BITS = psbf_pkg::MAX_PREAMBLE_BITS_DEF,
   parameter int MAX_SYNC_BITS     = psbf_pkg::MAX_SYNC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [psbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psbf_pkg::SYNC_WORD_W-1:0] csr_data,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  psbf_pkg::req_payload_type        req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  psbf_pkg::rsp_payload_type        rsp_payload,
   output int                               fail_count,
   output int                               pending_count,
   output int                               chunks_seen,
   output int                               frames_seen
);
   import psbf_pkg::*;

   // shadow copy of the framer registers and frame state
   logic [SYNC_WORD_W-1:0] sync_word_q;
   logic [SYNC_LEN_W-1:0]  sync_len_q;
   logic [PRE_LEN_W-1:0]   pre_len_q;
   logic                   low_bit_first_q;
   logic                   bypass_q;
   logic                   frame_open_q;

   // chunks predicted but not yet seen on the output
   rsp_payload_type expected_chunks[$];

   // bit packer for the serial stream
   logic [CHUNK_W-1:0] pack_acc;
   int                 pack_fill;

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      if (fail_count < 40) begin
         $display("ERROR at chunk %0d: %s got 0x%0h, expected 0x%0h",
                  chunks_seen, what, got_v, want_v);
      end
      fail_count++;
   endtask

   function automatic void push_chunk(input logic [CHUNK_W-1:0] bits, input int count);
      rsp_payload_type c;
      c.chunk_bits  = bits;
      c.chunk_count = CHUNK_CNT_W'(count);
      c.frame_done  = 1'b0;
      c.run_last    = 1'b0;
      expected_chunks.push_back(c);
   endfunction

   function automatic void shift_in_bit(input logic b);
      pack_acc[pack_fill] = b;
      pack_fill++;
      if (pack_fill == CHUNK_W) begin
         push_chunk(pack_acc, CHUNK_W);
         pack_acc  = '0;
         pack_fill = 0;
      end
   endfunction

   // expand one item into its chunk sequence
   function automatic void expand_item(input req_payload_type item);
      int              first_idx;
      int              pre_bits;
      int              sync_bits;
      rsp_payload_type tail;
      first_idx = expected_chunks.size();
      pack_acc  = '0;
      pack_fill = 0;
      if (bypass_q) begin
         if (item.byte_present) push_chunk(item.data_byte, CHUNK_W);
         else push_chunk('0, 0);
      end else begin
         // preamble and sync only open a new frame
         if (!frame_open_q) begin
            pre_bits  = (pre_len_q > MAX_PREAMBLE_BITS) ? MAX_PREAMBLE_BITS : int'(pre_len_q);
            sync_bits = (sync_len_q > MAX_SYNC_BITS) ? MAX_SYNC_BITS : int'(sync_len_q);
            for (int i = 0; i < pre_bits; i++) begin
               shift_in_bit(1'(i % 2));
            end
            for (int i = sync_bits - 1; i >= 0; i--) begin
               shift_in_bit(sync_word_q[i]);
            end
         end
         if (item.byte_present) begin
            for (int i = 0; i < BYTE_W; i++) begin
               shift_in_bit(low_bit_first_q ? item.data_byte[i] : item.data_byte[BYTE_W-1-i]);
            end
         end
         if (pack_fill > 0) push_chunk(pack_acc, pack_fill);
         // nothing to send still gives one empty chunk
         if (expected_chunks.size() == first_idx) push_chunk('0, 0);
      end
      tail            = expected_chunks.pop_back();
      tail.frame_done = item.frame_last;
      tail.run_last   = 1'b1;
      expected_chunks.push_back(tail);
      frame_open_q = !item.frame_last;
   endfunction

   task automatic check_chunk(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_chunks.size() == 0) begin
         report_mismatch("chunk with nothing expected, bits", got.chunk_bits, 0);
      end else begin
         want = expected_chunks.pop_front();
         if (got.chunk_bits !== want.chunk_bits)
            report_mismatch("chunk_bits", got.chunk_bits, want.chunk_bits);
         if (got.chunk_count !== want.chunk_count)
            report_mismatch("chunk_count", got.chunk_count, want.chunk_count);
         if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", got.frame_done, want.frame_done);
         if (got.run_last !== want.run_last)
            report_mismatch("run_last", got.run_last, want.run_last);
      end
      chunks_seen++;
      if (got.frame_done === 1'b1) frames_seen++;
   endtask

   // sample every channel at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         sync_word_q     = SYNC_WORD_RST;
         sync_len_q      = SYNC_LEN_RST;
         pre_len_q       = PRE_LEN_RST;
         low_bit_first_q = 1'b0;
         bypass_q        = 1'b0;
         frame_open_q    = 1'b0;
         expected_chunks.delete();
         fail_count      = 0;
         chunks_seen     = 0;
         frames_seen     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_WORD:     sync_word_q     = csr_data;
               CSR_SYNC_LEN:      sync_len_q      = csr_data[SYNC_LEN_W-1:0];
               CSR_PRE_LEN:       pre_len_q       = csr_data[PRE_LEN_W-1:0];
               CSR_LOW_BIT_FIRST: low_bit_first_q = csr_data[0];
               CSR_BYPASS:        bypass_q        = csr_data[0];
               default:           ;
            endcase
         end
         if (req_valid && !req_stall) expand_item(req_payload);
         if (rsp_valid && !rsp_stall) check_chunk(rsp_payload);
      end
      pending_count <= expected_chunks.size();
   end

endmodule

>>> bench/preamble_sync_bit_framer_unit_test.sv
`timescale 1ns / 1ps

module preamble_sync_bit_framer_unit_test;
   import psbf_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 150;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_BYPASS + 3'd1;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SYNC_WORD_W-1:0] csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;

   int fail_count;
   int pending_count;
   int chunks_seen;
   int frames_seen;

   int             cycle_count = 0;
   int             items_sent = 0;
   int             settings_applied = 0;
   int             hold_requests = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             phase_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   preamble_sync_bit_framer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   psbf_chunk_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .chunks_seen   (chunks_seen),
      .frames_seen   (frames_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d chunks still expected",
                  cycle_count, pending_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // output side: random stall modes, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_stall    <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            phase_left <= $urandom_range(10, 80);
         end else begin
            phase_left <= phase_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (cycle_count % 7) < 3;
         endcase
      end
   end

   function automatic logic [SYNC_WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_payload_type make_item(input logic [BYTE_W-1:0] data,
                                                 input logic present, input logic last);
      req_payload_type item;
      item.data_byte    = data;
      item.byte_present = present;
      item.frame_last   = last;
      return item;
   endfunction

   // one item transfer; valid stays high for a following item
   task automatic send_item(input req_payload_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_req(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold the input until every predicted chunk has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [SYNC_WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // narrow registers get random upper data bits, which must be ignored
   task automatic apply_config(input logic [SYNC_WORD_W-1:0] sync_word,
                               input logic [SYNC_LEN_W-1:0] sync_len,
                               input logic [PRE_LEN_W-1:0] pre_len,
                               input logic low_bit_first, input logic bypass);
      logic [SYNC_WORD_W-1:0] word;
      wait_drained();
      csr_write(CSR_SYNC_WORD, sync_word);
      word = rand64();
      word[SYNC_LEN_W-1:0] = sync_len;
      csr_write(CSR_SYNC_LEN, word);
      word = rand64();
      word[PRE_LEN_W-1:0] = pre_len;
      csr_write(CSR_PRE_LEN, word);
      word = rand64();
      word[0] = low_bit_first;
      csr_write(CSR_LOW_BIT_FIRST, word);
      word = rand64();
      word[0] = bypass;
      csr_write(CSR_BYPASS, word);
      settings_applied++;
   endtask

   // frames of random content in bursts, with some noise items mixed in
   task automatic run_random_phase(input int n_items);
      int              sent;
      int              burst_left;
      int              frame_len;
      req_payload_type item;
      sent = 0;
      burst_left = 0;
      while (sent < n_items) begin
         frame_len = $urandom_range(1, 6);
         for (int k = 0; k < frame_len && sent < n_items; k++) begin
            if ($urandom_range(0, 11) == 0)
               item = make_item(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
            else
               item = make_item(BYTE_W'($urandom), $urandom_range(0, 7) != 0,
                                k == frame_len - 1);
            if (burst_left == 0) begin
               idle_req($urandom_range(1, 7));
               burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            send_item(item);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      logic [SYNC_LEN_W-1:0] sync_len;
      logic [PRE_LEN_W-1:0]  pre_len;
      logic [SYNC_WORD_W-1:0] sync_word;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: long preamble, 32-bit sync, MSB first
      send_item(make_item(8'h00, 1'b1, 1'b0));
      send_item(make_item(8'hFF, 1'b1, 1'b0));
      send_item(make_item(8'hA5, 1'b1, 1'b1));
      // empty frame, then absent bytes inside an open frame
      send_item(make_item(8'h00, 1'b0, 1'b1));
      send_item(make_item(8'h3C, 1'b0, 1'b0));
      send_item(make_item(8'h00, 1'b0, 1'b0));
      send_item(make_item(8'h5A, 1'b1, 1'b1));

      // writes to unused indexes change nothing
      wait_drained();
      for (int k = CSR_FIRST_UNUSED; k < (1 << CSR_INDEX_W); k++) begin
         csr_write(CSR_INDEX_W'(k), rand64());
      end
      send_item(make_item(8'h81, 1'b1, 1'b1));

      // longest frame start: full preamble, oversized sync length
      apply_config('1, 7'd127, 8'd255, 1'b0, 1'b0);
      send_item(make_item(8'h80, 1'b1, 1'b1));

      // no preamble or sync, LSB first; empty item gives an empty chunk
      apply_config(rand64(), 7'd0, 8'd0, 1'b1, 1'b0);
      send_item(make_item(8'h00, 1'b0, 1'b1));
      send_item(make_item(8'h01, 1'b1, 1'b0));
      send_item(make_item(8'h80, 1'b1, 1'b1));

      // odd lengths: 3 + 5 fill whole chunks, a one-bit preamble with 64-bit sync leaves a partial last chunk
      apply_config(rand64(), 7'd5, 8'd3, 1'b1, 1'b0);
      send_item(make_item(8'hC3, 1'b1, 1'b1));
      send_item(make_item(8'h00, 1'b0, 1'b1));
      apply_config(rand64(), 7'd64, 8'd1, 1'b0, 1'b0);
      send_item(make_item(8'h7E, 1'b1, 1'b1));

      // bypass still tracks frames: the open frame skips the preamble afterwards
      sync_word = rand64();
      apply_config(sync_word, 7'd12, 8'd10, 1'b0, 1'b1);
      send_item(make_item(8'hFF, 1'b1, 1'b0));
      send_item(make_item(8'h00, 1'b0, 1'b0));
      send_item(make_item(8'h00, 1'b1, 1'b0));
      apply_config(sync_word, 7'd12, 8'd10, 1'b0, 1'b0);
      send_item(make_item(8'h96, 1'b1, 1'b1));
      send_item(make_item(8'h69, 1'b1, 1'b1));

      // back pressure: output held off while items keep coming
      apply_config(rand64(), 7'd8, 8'd16, 1'b0, 1'b0);
      send_item(make_item(BYTE_W'($urandom), 1'b1, 1'b0));
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 20; k++) begin
         send_item(make_item(BYTE_W'($urandom), 1'b1, k == 19));
      end
      wait_drained();

      // random phases over a spread of settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_config('1, 7'd127, 8'd255, 1'($urandom), 1'b0);
            1: apply_config(rand64(), 7'd0, 8'd0, 1'b1, 1'b0);
            2: apply_config(rand64(), 7'd32, 8'd64, 1'b0, 1'b1);
            default: begin
               sync_len  = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(60, 127))
                                                       : 7'($urandom_range(0, 20));
               pre_len   = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(200, 255))
                                                       : 8'($urandom_range(0, 24));
               sync_word = (p == 3) ? '0 : rand64();
               apply_config(sync_word, sync_len, pre_len, 1'($urandom),
                            1'($urandom_range(0, 4) == 0));
            end
         endcase
         run_random_phase(15);
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("run covered %0d items under %0d register settings, one long output hold-off",
               items_sent, settings_applied);
      $display("checked %0d chunks closing %0d frames", chunks_seen, frames_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/psbf_pkg.sv
design/psbf_front.sv
design/psbf_queue.sv
design/psbf_back.sv
design/preamble_sync_bit_framer_unit.sv
bench/psbf_chunk_checker.sv
bench/preamble_sync_bit_framer_unit_test.sv
